FILE: src/ehcb_pkg.sv
package ehcb_pkg;

    localparam int NUM_CLUSTERS_DEF = 8;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [6:0] PCT_MAX   = 7'd100;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_AVERAGE_SHIFT  = 3'd0;
    localparam logic [2:0] REG_UP_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_DOWN_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_FLIP_COUNT     = 3'd3;
    localparam logic [2:0] REG_BALANCER_ON    = 3'd4;

    localparam logic [3:0] RST_AVERAGE_SHIFT  = 4'd3;
    localparam logic [6:0] RST_UP_THRESHOLD   = 7'd70;
    localparam logic [6:0] RST_DOWN_THRESHOLD = 7'd30;
    localparam logic [7:0] RST_FLIP_COUNT     = 8'd3;
    localparam logic       RST_BALANCER_ON    = 1'b1;

    typedef struct packed {
        logic [2:0] cluster_index;
        logic [6:0] sample_pct;
    } in_word_t;

    typedef struct packed {
        logic [2:0] out_cluster;
        logic [6:0] average_pct;
        logic       wants_big;
        logic       switched;
    } out_word_t;

    // one memory entry per cluster
    typedef struct packed {
        logic [6:0] average_level;
        logic [7:0] above_count;
        logic [7:0] below_count;
        logic       prefer_big_flag;
    } entry_t;

    typedef struct packed {
        logic [3:0] average_shift;
        logic [6:0] up_threshold;
        logic [6:0] down_threshold;
        logic [7:0] flip_count;
        logic       balancer_on;
    } cfg_t;

endpackage

FILE: src/ehcb_update.sv
module ehcb_update (
    input  ehcb_pkg::cfg_t      cfg,
    input  ehcb_pkg::in_word_t  word,
    input  logic                in_range,
    input  ehcb_pkg::entry_t    cur,
    output ehcb_pkg::entry_t    nxt,
    output logic                wr_en,
    output ehcb_pkg::out_word_t res
);
    import ehcb_pkg::*;

    logic [6:0]  sample_sat;
    logic [22:0] scaled;
    logic [22:0] shifted;
    logic [6:0]  avg;
    logic [7:0]  above;
    logic [7:0]  below;
    logic        flip;
    entry_t      upd;

    always_comb
    begin
        sample_sat = (word.sample_pct > PCT_MAX) ? PCT_MAX : word.sample_pct;

        // avg * (2^s - 1) + sample, then >> s
        scaled  = ({16'd0, cur.average_level} << cfg.average_shift)
                - {16'd0, cur.average_level} + {16'd0, sample_sat};
        shifted = scaled >> cfg.average_shift;
        if (cfg.average_shift == 4'd0)
        begin
            avg = sample_sat;
        end
        else if (shifted > {16'd0, PCT_MAX})
        begin
            avg = PCT_MAX;
        end
        else
        begin
            avg = shifted[6:0];
        end

        above = cur.above_count;
        below = cur.below_count;
        if (avg >= cfg.up_threshold)
        begin
            above = (cur.above_count < COUNT_MAX) ? cur.above_count + 8'd1 : COUNT_MAX;
            below = 8'd0;
        end
        else if (avg <= cfg.down_threshold)
        begin
            below = (cur.below_count < COUNT_MAX) ? cur.below_count + 8'd1 : COUNT_MAX;
            above = 8'd0;
        end
        else
        begin
            if (cur.above_count != 8'd0)
            begin
                above = cur.above_count - 8'd1;
            end
            if (cur.below_count != 8'd0)
            begin
                below = cur.below_count - 8'd1;
            end
        end

        flip = (!cur.prefer_big_flag && above >= cfg.flip_count)
            || (cur.prefer_big_flag && below >= cfg.flip_count);

        upd.average_level   = avg;
        upd.above_count     = flip ? 8'd0 : above;
        upd.below_count     = flip ? 8'd0 : below;
        upd.prefer_big_flag = cur.prefer_big_flag ^ flip;

        wr_en = in_range && cfg.balancer_on;
        nxt   = wr_en ? upd : cur;

        res.out_cluster = word.cluster_index;
        if (!in_range)
        begin
            res.average_pct = 7'd0;
            res.wants_big   = 1'b0;
            res.switched    = 1'b0;
        end
        else
        begin
            res.average_pct = nxt.average_level;
            res.wants_big   = nxt.prefer_big_flag;
            res.switched    = wr_en && flip;
        end
    end

endmodule

FILE: src/ewma_hysteresis_cluster_balancer.sv
// Per-cluster EWMA utilization tracker with hysteresis on a big/little preference.
// Takes one sample word per clock unless stalled and returns one result word per
// sample. The memory is read at the accept edge. The update, the write-back and the
// load of the result register happen at the edge where the update stage advances,
// which a stalled result can hold back. Per-cluster state (average, above and
// below counters, preference) sits in one synchronous memory; a bypass register
// feeds the just-written entry to a following sample of the same cluster, so
// back-to-back samples to one cluster run at full rate. Entries read as zero until
// first written (per-entry valid flops), so there is no clearing pass after reset.
// User must write configuration over the APB-style port while idle; not enforced.
module ewma_hysteresis_cluster_balancer #(
    parameter int NUM_CLUSTERS = ehcb_pkg::NUM_CLUSTERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  ehcb_pkg::in_word_t            sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ehcb_pkg::out_word_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ehcb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ehcb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ehcb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ehcb_pkg::*;

    // only the first eight clusters are reachable with a 3-bit index
    localparam int DEPTH = (NUM_CLUSTERS < 8) ? NUM_CLUSTERS : 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t            cfg_reg;
    logic [2:0]      reg_index;

    entry_t          mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    logic            s1_valid_reg;
    in_word_t        s1_word_reg;
    logic            s1_range_reg;
    entry_t          rd_data_reg;
    logic            rd_ok_reg;
    logic            byp_reg;
    entry_t          byp_data_reg;
    logic [AW-1:0]   s1_addr_reg;

    logic            result_valid_reg;
    out_word_t       result_reg;

    logic            accept;
    logic            s1_adv;
    logic            in_range;
    logic [AW-1:0]   rd_addr;
    entry_t          cur;
    entry_t          nxt;
    logic            upd_wr;
    logic            wr_en;
    out_word_t       res;

    // configuration port
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.average_shift  <= RST_AVERAGE_SHIFT;
            cfg_reg.up_threshold   <= RST_UP_THRESHOLD;
            cfg_reg.down_threshold <= RST_DOWN_THRESHOLD;
            cfg_reg.flip_count     <= RST_FLIP_COUNT;
            cfg_reg.balancer_on    <= RST_BALANCER_ON;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_index)
                REG_AVERAGE_SHIFT:  cfg_reg.average_shift  <= pwdata[3:0];
                REG_UP_THRESHOLD:   cfg_reg.up_threshold   <= pwdata[6:0];
                REG_DOWN_THRESHOLD: cfg_reg.down_threshold <= pwdata[6:0];
                REG_FLIP_COUNT:     cfg_reg.flip_count     <= pwdata[7:0];
                REG_BALANCER_ON:    cfg_reg.balancer_on    <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_AVERAGE_SHIFT:  prdata = {28'd0, cfg_reg.average_shift};
            REG_UP_THRESHOLD:   prdata = {25'd0, cfg_reg.up_threshold};
            REG_DOWN_THRESHOLD: prdata = {25'd0, cfg_reg.down_threshold};
            REG_FLIP_COUNT:     prdata = {24'd0, cfg_reg.flip_count};
            REG_BALANCER_ON:    prdata = {31'd0, cfg_reg.balancer_on};
            default:            prdata = '0;
        endcase
    end

    // handshake
    assign s1_adv       = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !s1_adv;
    assign accept       = sample_valid && !sample_stall;
    assign in_range     = {29'd0, sample.cluster_index} < 32'(NUM_CLUSTERS);
    assign rd_addr      = sample.cluster_index[AW-1:0];
    assign wr_en        = s1_adv && upd_wr;

    always_comb
    begin
        if (byp_reg)
        begin
            cur = byp_data_reg;
        end
        else if (rd_ok_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    ehcb_update u_update (
        .cfg      (cfg_reg),
        .word     (s1_word_reg),
        .in_range (s1_range_reg),
        .cur      (cur),
        .nxt      (nxt),
        .wr_en    (upd_wr),
        .res      (res)
    );

    // state memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= nxt;
        end
        if (accept && in_range)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (accept)
        begin
            s1_word_reg  <= sample;
            s1_addr_reg  <= rd_addr;
            byp_data_reg <= nxt;
        end
        if (s1_adv)
        begin
            result_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            s1_range_reg     <= 1'b0;
            rd_ok_reg        <= 1'b0;
            byp_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_range_reg <= in_range;
                rd_ok_reg    <= in_range && valid_reg[rd_addr];
                // same-edge write to the entry being read: memory gives stale data
                byp_reg      <= in_range && wr_en && (s1_addr_reg == rd_addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                byp_reg      <= 1'b0;
            end
            if (s1_adv)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_switch_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.switched |-> cfg_reg.balancer_on)
        else $error("switched result while balancer is off");

    a_bypass_with_item: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> s1_valid_reg)
        else $error("bypass flag set with empty update stage");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && result_valid && result_stall |-> sample_stall)
        else $error("input taken while update stage is blocked");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ({29'd0, result.out_cluster} >= 32'(NUM_CLUSTERS))
        |-> result.average_pct == 7'd0 && !result.wants_big && !result.switched)
        else $error("nonzero result for absent cluster");

    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !$past(sample_stall))
        else $error("write-back while update stage stalled");

endmodule
